// ===== design/assert_macros.svh =====
// assert_macros.svh: assertion shorthands shared by the RTL
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold
`define ASSERT_DEF(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// expression must never be true
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== design/eucl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eucl_pkg: shared types and constants for the Euclidean distance block
// Widths of the sum and root, root step count, sequencer state type.
// ----------------------------------------------------------------------------
package eucl_pkg;

	// default coordinate width (signed Q8.8)
	localparam int COORD_BITS_DEF = 16;

	// sum of squares, unsigned Q22.16
	localparam int SUM_W = 38;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// floor root of the sum, unsigned Q11.8; one root bit per step
	localparam int ROOT_W = SUM_W / 2;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int CNT_W = $clog2(ROOT_STEPS);
	localparam int REM_W = ROOT_W + 2;

	// largest magnitude whose square still fits the sum
	localparam int DIFF_SQ_LIMIT = (1 << ROOT_W) - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQR,
		ST_ACC,
		ST_ROOT
	} dist_state_t;

endpackage

// ===== design/euclidean_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_top: streaming L2 distance between two vectors
// Accumulates squared coordinate differences; on the last pair emits the
// saturating sum of squares and its floor square root.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | coord_a, coord_b, last_pair
//  out     | out_valid/out_stall| squared_sum, dist_res
//
//  A pair that is not last passes accept and difference, square and
//  accumulate. A last pair then runs the root loop of ROOT_STEPS steps, one root bit
//  per cycle through a shared compare/subtract unit; only its final step can stall.
//  in_stall is high whenever the sequencer is busy.
//  Reset clears the sequencer, the running sum and the output valid.
//  A waiting result does not block new pairs; only the final root step
//  waits while the output register still holds an untaken transaction.
//
`include "assert_macros.svh"

module euclidean_distance_top #(
	parameter int COORD_BITS = eucl_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  coord_a,
	input  logic signed [COORD_BITS-1:0]  coord_b,
	input  logic                          last_pair,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [eucl_pkg::SUM_W-1:0]    squared_sum,
	output logic [eucl_pkg::ROOT_W-1:0]   dist_res
);

	// difference needs one extra bit; compare width covers the square limit
	localparam int MAG_W = COORD_BITS + 1;
	localparam int CMP_W = (MAG_W > eucl_pkg::ROOT_W) ? MAG_W : eucl_pkg::ROOT_W;

	eucl_pkg::dist_state_t state_q, state_nxt;

	// stage 1: magnitude of the difference
	logic [MAG_W-1:0]               diff;
	logic [MAG_W-1:0]               mag;
	logic [CMP_W-1:0]               mag_q;
	logic                           last_q;

	// stage 2: saturated square
	logic [eucl_pkg::ROOT_W-1:0]    sq_op;
	logic [eucl_pkg::SUM_W-1:0]     sq_prod;
	logic [eucl_pkg::SUM_W-1:0]     sq_q;

	// stage 3: running sum
	logic [eucl_pkg::SUM_W-1:0]     sum_q;
	logic [eucl_pkg::SUM_W:0]       sum_add;
	logic [eucl_pkg::SUM_W-1:0]     sum_new;

	// root unit
	logic [eucl_pkg::SUM_W-1:0]     sumcap_q;
	logic [eucl_pkg::SUM_W-1:0]     rad_q;
	logic [eucl_pkg::REM_W-1:0]     rem_q;
	logic [eucl_pkg::ROOT_W-1:0]    root_q;
	logic [eucl_pkg::CNT_W-1:0]     cnt_q;
	logic [eucl_pkg::REM_W+1:0]     rem_sh;
	logic [eucl_pkg::REM_W+1:0]     trial;
	logic                           ge;
	logic [eucl_pkg::REM_W-1:0]     rem_nxt;
	logic [eucl_pkg::ROOT_W-1:0]    root_nxt;
	logic                           step_last;

	// output register
	logic                           out_valid_q;
	logic [eucl_pkg::SUM_W-1:0]     squared_sum_q;
	logic [eucl_pkg::ROOT_W-1:0]    dist_res_q;
	logic                           out_free;

	// sequencer controls
	logic in_take;
	logic acc_en;
	logic root_start;
	logic root_step;
	logic root_done;

	// ---------------- datapath (combinational) ----------------
	assign diff = {coord_a[COORD_BITS-1], coord_a} - {coord_b[COORD_BITS-1], coord_b};
	assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

	// anything above the limit would overflow the sum: pin at max
	assign sq_op   = mag_q[eucl_pkg::ROOT_W-1:0];
	assign sq_prod = sq_op * sq_op;

	assign sum_add = {1'b0, sum_q} + {1'b0, sq_q};
	assign sum_new = sum_add[eucl_pkg::SUM_W] ? eucl_pkg::SUM_MAX
		: sum_add[eucl_pkg::SUM_W-1:0];

	// digit-by-digit root: bring down two radicand bits, try (root<<2)|1
	assign rem_sh   = {rem_q, rad_q[eucl_pkg::SUM_W-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign ge       = (rem_sh >= trial);
	assign rem_nxt  = ge ? eucl_pkg::REM_W'(rem_sh - trial) : eucl_pkg::REM_W'(rem_sh);
	assign root_nxt = {root_q[eucl_pkg::ROOT_W-2:0], ge};
	assign step_last = (cnt_q == eucl_pkg::CNT_W'(eucl_pkg::ROOT_STEPS - 1));

	assign out_free = !out_valid_q || !out_stall;

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			eucl_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = eucl_pkg::ST_SQR;
			end
			eucl_pkg::ST_SQR: state_nxt = eucl_pkg::ST_ACC;
			eucl_pkg::ST_ACC: begin
				state_nxt = last_q ? eucl_pkg::ST_ROOT : eucl_pkg::ST_IDLE;
			end
			eucl_pkg::ST_ROOT: begin
				if (step_last && out_free) state_nxt = eucl_pkg::ST_IDLE;
			end
			default: state_nxt = eucl_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		in_stall   = 1'b1;
		in_take    = 1'b0;
		acc_en     = 1'b0;
		root_start = 1'b0;
		root_step  = 1'b0;
		root_done  = 1'b0;
		case (state_q)
			eucl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				in_take  = in_valid;
			end
			eucl_pkg::ST_SQR: ;
			eucl_pkg::ST_ACC: begin
				acc_en     = 1'b1;
				root_start = last_q;
			end
			eucl_pkg::ST_ROOT: begin
				// the final step writes the result, so it waits for a free slot
				root_step = !step_last || out_free;
				root_done = step_last && out_free;
			end
			default: ;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= eucl_pkg::ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc_en) sum_q <= last_q ? '0 : sum_new;
			if (root_start) cnt_q <= '0;
			else if (root_step && !step_last) cnt_q <= cnt_q + eucl_pkg::CNT_W'(1);
			if (root_done) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mag_q  <= CMP_W'(mag);
			last_q <= last_pair;
		end
		if (state_q == eucl_pkg::ST_SQR) begin
			sq_q <= (mag_q > CMP_W'(eucl_pkg::DIFF_SQ_LIMIT)) ? eucl_pkg::SUM_MAX : sq_prod;
		end
		if (root_start) begin
			sumcap_q <= sum_new;
			rad_q    <= sum_new;
			rem_q    <= '0;
			root_q   <= '0;
		end else if (root_step) begin
			rad_q  <= {rad_q[eucl_pkg::SUM_W-3:0], 2'b00};
			rem_q  <= rem_nxt;
			root_q <= root_nxt;
		end
		if (root_done) begin
			squared_sum_q <= sumcap_q;
			dist_res_q    <= root_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign squared_sum = squared_sum_q;
	assign dist_res    = dist_res_q;

	// ---------------- assertions ----------------
	// a new result only ever comes out of the root loop
	`ASSERT_DEF(a_result_from_root, $rose(out_valid) |-> $past(state_q) == eucl_pkg::ST_ROOT)
	// the sum is cleared once the last pair has been folded in
	`ASSERT_DEF(a_sum_cleared, $rose(out_valid) |-> sum_q == '0)
	// root is a floor: r*r <= s < (r+1)*(r+1)
	`ASSERT_DEF(a_root_low, out_valid |-> ({1'b0, dist_res} * {1'b0, dist_res}) <= {2'b00, squared_sum})
	`ASSERT_DEF(a_root_high, out_valid |-> ({1'b0, dist_res} + (eucl_pkg::ROOT_W+1)'(1)) * ({1'b0, dist_res} + (eucl_pkg::ROOT_W+1)'(1)) > {2'b00, squared_sum})

endmodule
